[rtl/max_pool_2d_stream_top_macros.svh]
// Assertion helpers shared by the pooling block
`ifndef MAX_POOL_2D_STREAM_TOP_MACROS_SVH
`define MAX_POOL_2D_STREAM_TOP_MACROS_SVH

// Same-cycle implication under reset
`define MPS_ASSERT_NOW(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Next-cycle implication under reset
`define MPS_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

[rtl/mps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, register codes and float helpers for the max pooling block.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam logic [31:0] NEG_INF = 32'hFF80_0000;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam int WAIT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT   = 3'd0,
    REG_IN_WIDTH    = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_POOL_HEIGHT = 3'd3,
    REG_POOL_WIDTH  = 3'd4,
    REG_STRIDE_ROWS = 3'd5,
    REG_STRIDE_COLS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_WAIT = 2'd2
  } seq_state_e;

  // Read request from the sequencer to the fold stage
  typedef struct packed {
    logic en;
    logic last;
    logic done;
  } rd_ctl_t;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // Ordered greater-than on single-precision bits; false for NaN and equal
  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res = 1'b0;
    end else if (!a[31] && b[31]) begin
      res = 1'b1;
    end else if (a[31] && !b[31]) begin
      res = 1'b0;
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    f_gt = res;
  endfunction

endpackage

[rtl/max_pool_2d_stream_top.sv]
`timescale 1ns / 1ps
// Output: a window-completing element gives its maximum through the store read,
// fold, hold and output registers; other elements give nothing.
// Input: one plain element per cycle while idle; a window-completing element stalls
// input while the one read port of the line store walks the window and the fold drains.
// Reset: position returns to zero and registers to 2,2,1,2,2,2,2; store not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top
// Streaming 2-D max pooling over an HWC float32 image with a line store.
// ----------------------------------------------------------------------------
`include "max_pool_2d_stream_top_macros.svh"

module max_pool_2d_stream_top #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_POOL     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] max_value
  output logic                          m_axis_tlast   // image_done
);

  localparam int DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = (DEPTH < 2) ? 1 : $clog2(DEPTH);

  logic             we, busy;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      rdata;
  mps_pkg::rd_ctl_t rd;

  mps_ctrl #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS), .MAX_POOL(MAX_POOL), .AW(AW)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .fold_busy_i(busy), .we_o(we), .waddr_o(waddr), .raddr_o(raddr), .rd_o(rd)
  );

  mps_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(s_axis_tdata),
    .re_i(rd.en), .raddr_i(raddr), .rdata_o(rdata)
  );

  mps_fold u_fold (
    .clk_i, .rst_ni, .rd_i(rd), .rdata_i(rdata), .busy_o(busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

  // Store reads and input writes never share a cycle
  `MPS_ASSERT_NOW(a_no_rw_clash, clk_i, rst_ni, rd.en, !we, "read during write")
  // A window in flight blocks new requests
  `MPS_ASSERT_NOW(a_busy_stall, clk_i, rst_ni, busy, !s_axis_tready, "request taken while busy")
  // Last read of a window leaves the fold busy next cycle
  `MPS_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, rd.en && rd.last, busy, "fold not busy")

endmodule

[rtl/mps_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_store
// Line store: synchronous RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mps_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_ctrl
// Configuration registers, raster position tracking, window detection and
// the read sequencer that walks a completed window through the line store.
// ----------------------------------------------------------------------------
module mps_ctrl #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_POOL     = 4,
  parameter int AW           = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          fold_busy_i,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [AW-1:0]                 raddr_o,
  output mps_pkg::rd_ctl_t              rd_o
);

  localparam int HL = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int WL = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int CL = (MAX_CHANNELS < 127) ? MAX_CHANNELS : 127;
  localparam int RW = (HL < 2) ? 1 : $clog2(HL);
  localparam int CW = (WL < 2) ? 1 : $clog2(WL);
  localparam int HW = (CL < 2) ? 1 : $clog2(CL);
  localparam int SW = (MAX_POOL < 2) ? 1 : $clog2(MAX_POOL);
  localparam int KW = $clog2(MAX_POOL + 1);

  // Configuration registers
  logic [8:0] in_height_q, in_width_q;
  logic [6:0] channels_q;
  logic [2:0] pool_h_q, pool_w_q, str_r_q, str_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= 9'd2;
      in_width_q  <= 9'd2;
      channels_q  <= 7'd1;
      pool_h_q    <= 3'd2;
      pool_w_q    <= 3'd2;
      str_r_q     <= 3'd2;
      str_c_q     <= 3'd2;
    end else if (cfg_we_i) begin
      case (mps_pkg::cfg_reg_e'(cfg_idx_i))
        mps_pkg::REG_IN_HEIGHT:   in_height_q <= cfg_wdata_i;
        mps_pkg::REG_IN_WIDTH:    in_width_q  <= cfg_wdata_i;
        mps_pkg::REG_CHANNELS:    channels_q  <= cfg_wdata_i[6:0];
        mps_pkg::REG_POOL_HEIGHT: pool_h_q    <= cfg_wdata_i[2:0];
        mps_pkg::REG_POOL_WIDTH:  pool_w_q    <= cfg_wdata_i[2:0];
        mps_pkg::REG_STRIDE_ROWS: str_r_q     <= cfg_wdata_i[2:0];
        mps_pkg::REG_STRIDE_COLS: str_c_q     <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= mps_pkg::CFG_IDX_W'(mps_pkg::REG_STRIDE_COLS));

  // Clamp registers into their working ranges
  logic [8:0] h_c, w_c;
  logic [6:0] nc_c;
  logic [2:0] ph_c, pw_c, sr_c, sc_c;

  always_comb begin
    h_c  = (in_height_q == 9'd0) ? 9'd1 :
           (32'(in_height_q) > HL) ? 9'(HL) : in_height_q;
    w_c  = (in_width_q == 9'd0) ? 9'd1 :
           (32'(in_width_q) > WL) ? 9'(WL) : in_width_q;
    nc_c = (channels_q == 7'd0) ? 7'd1 :
           (32'(channels_q) > CL) ? 7'(CL) : channels_q;
    ph_c = (pool_h_q == 3'd0) ? 3'd1 :
           (32'(pool_h_q) > MAX_POOL) ? 3'(MAX_POOL) : pool_h_q;
    pw_c = (pool_w_q == 3'd0) ? 3'd1 :
           (32'(pool_w_q) > MAX_POOL) ? 3'(MAX_POOL) : pool_w_q;
    sr_c = (str_r_q == 3'd0) ? 3'd1 : str_r_q;
    sc_c = (str_c_q == 3'd0) ? 3'd1 : str_c_q;
  end

  // Position and stride phase state
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [HW-1:0] chan_q, chan_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [mps_pkg::WAIT_W-1:0] rwait_q, rwait_d, cwait_q, cwait_d;
  logic [mps_pkg::WAIT_W-1:0] reff, ceff;
  logic accept, hit, done;
  logic last_chan, last_col, last_row;

  // Rows (columns) left until the next window bottom (right) edge
  assign reff = (row_q == '0) ? mps_pkg::WAIT_W'(ph_c - 3'd1) : rwait_q;
  assign ceff = (col_q == '0) ? mps_pkg::WAIT_W'(pw_c - 3'd1) : cwait_q;

  assign last_chan = (10'(chan_q) + 10'd1) == 10'(nc_c);
  assign last_col  = (10'(col_q) + 10'd1) == 10'(w_c);
  assign last_row  = (10'(row_q) + 10'd1) == 10'(h_c);

  assign hit  = (9'(ph_c) <= h_c) && (9'(pw_c) <= w_c) && (reff == '0) && (ceff == '0);
  assign done = hit && last_chan &&
                ((10'(row_q) + 10'(sr_c)) >= 10'(h_c)) &&
                ((10'(col_q) + 10'(sc_c)) >= 10'(w_c));

  // Advance the raster position
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    chan_d  = chan_q;
    slot_d  = slot_q;
    rwait_d = rwait_q;
    cwait_d = cwait_q;
    if (accept) begin
      chan_d = last_chan ? '0 : chan_q + HW'(1);
      if (last_chan) begin
        col_d   = last_col ? '0 : col_q + CW'(1);
        cwait_d = (ceff == '0) ? mps_pkg::WAIT_W'(sc_c - 3'd1) : ceff - 1'b1;
        if (last_col) begin
          row_d   = last_row ? '0 : row_q + RW'(1);
          rwait_d = (reff == '0) ? mps_pkg::WAIT_W'(sr_c - 3'd1) : reff - 1'b1;
          if (last_row || (32'(slot_q) == MAX_POOL - 1)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_q + SW'(1);
          end
        end
      end
    end
    if (cfg_hit) begin
      row_d  = '0;
      col_d  = '0;
      chan_d = '0;
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      chan_q  <= '0;
      slot_q  <= '0;
      rwait_q <= '0;
      cwait_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      chan_q  <= chan_d;
      slot_q  <= slot_d;
      rwait_q <= rwait_d;
      cwait_q <= cwait_d;
    end
  end

  // Sequencer state
  mps_pkg::seq_state_e state_q, state_d;
  logic [SW-1:0] rslot_q, rslot_d;
  logic [CW-1:0] col0_q, col0_d, rcol_q, rcol_d;
  logic [HW-1:0] rchan_q, rchan_d;
  logic [KW-1:0] kh_q, kh_d, kw_q, kw_d;
  logic          done_q, done_d;
  logic          rd_last;
  logic [SW:0]   start_slot;

  assign rd_last = (kh_q == KW'(ph_c - 3'd1)) && (kw_q == KW'(pw_c - 3'd1));

  // Oldest window row sits ph-1 slots behind the current one
  always_comb begin
    start_slot = (SW+1)'(slot_q) + (SW+1)'(MAX_POOL) - (SW+1)'(ph_c - 3'd1);
    if (32'(start_slot) >= MAX_POOL) begin
      start_slot = start_slot - (SW+1)'(MAX_POOL);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mps_pkg::ST_IDLE: if (accept && hit) state_d = mps_pkg::ST_READ;
      mps_pkg::ST_READ: if (rd_last) state_d = mps_pkg::ST_WAIT;
      mps_pkg::ST_WAIT: if (!fold_busy_i) state_d = mps_pkg::ST_IDLE;
      default: state_d = mps_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_o       = '0;
    case (state_q)
      mps_pkg::ST_IDLE: in_ready_o = 1'b1;
      mps_pkg::ST_READ: begin
        rd_o.en   = 1'b1;
        rd_o.last = rd_last;
        rd_o.done = done_q;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Window walk: row by row, left to right
  always_comb begin
    rslot_d = rslot_q;
    col0_d  = col0_q;
    rcol_d  = rcol_q;
    rchan_d = rchan_q;
    kh_d    = kh_q;
    kw_d    = kw_q;
    done_d  = done_q;
    if (accept && hit) begin
      rslot_d = SW'(start_slot);
      col0_d  = col_q + CW'(1) - CW'(pw_c);
      rcol_d  = col_q + CW'(1) - CW'(pw_c);
      rchan_d = chan_q;
      kh_d    = '0;
      kw_d    = '0;
      done_d  = done;
    end else if (state_q == mps_pkg::ST_READ) begin
      if (kw_q == KW'(pw_c - 3'd1)) begin
        kw_d   = '0;
        rcol_d = col0_q;
        kh_d   = kh_q + KW'(1);
        rslot_d = (32'(rslot_q) == MAX_POOL - 1) ? '0 : rslot_q + SW'(1);
      end else begin
        kw_d   = kw_q + KW'(1);
        rcol_d = rcol_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q <= rslot_d;
    col0_q  <= col0_d;
    rcol_q  <= rcol_d;
    rchan_q <= rchan_d;
    kh_q    <= kh_d;
    kw_q    <= kw_d;
    done_q  <= done_d;
  end

  // Store addresses: (slot * MAX_WIDTH + col) * MAX_CHANNELS + channel
  assign we_o    = accept;
  assign waddr_o = (AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q)) * AW'(MAX_CHANNELS)
                   + AW'(chan_q);
  assign raddr_o = (AW'(rslot_q) * AW'(MAX_WIDTH) + AW'(rcol_q)) * AW'(MAX_CHANNELS)
                   + AW'(rchan_q);

endmodule

[rtl/mps_fold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_fold
// Running maximum over returned store words, result hold and output register.
// ----------------------------------------------------------------------------
module mps_fold (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mps_pkg::rd_ctl_t rd_i,
  input  logic [31:0]      rdata_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_data_o,
  output logic             out_last_o
);

  mps_pkg::rd_ctl_t rd_q;
  logic [31:0] acc_q, acc_d, fold_val;
  logic        pend_q, pend_d, pend_done_q;
  logic [31:0] pend_val_q;
  logic        ov_q, ov_d;
  logic [31:0] od_q;
  logic        ol_q;
  logic        load_out;

  // Align the request with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q <= rd_i;
    end
  end

  // Keep the accumulator only when strictly greater
  assign fold_val = mps_pkg::f_gt(acc_q, rdata_i) ? acc_q : rdata_i;

  always_comb begin
    acc_d = acc_q;
    if (rd_q.en) begin
      acc_d = rd_q.last ? mps_pkg::NEG_INF : fold_val;
    end
  end

  assign load_out = pend_q && (!ov_q || out_ready_i);

  always_comb begin
    pend_d = pend_q;
    if (load_out) pend_d = 1'b0;
    if (rd_q.en && rd_q.last) pend_d = 1'b1;
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (load_out) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= mps_pkg::NEG_INF;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  // Hold the finished maximum, then move it to the output register
  always_ff @(posedge clk_i) begin
    if (rd_q.en && rd_q.last) begin
      pend_val_q  <= fold_val;
      pend_done_q <= rd_q.done;
    end
    if (load_out) begin
      od_q <= pend_val_q;
      ol_q <= pend_done_q;
    end
  end

  assign busy_o      = rd_q.en || pend_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed test of the streaming max pooling block. A software
// pooling model tracks the raster position and a line store, predicts each
// window maximum and the image-done flag, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MPOOL = 4;
  localparam int MWID  = 256;
  localparam int MCH   = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mps_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [mps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [31:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [31:0] m_data;
  logic m_last;

  int send_idle = 0;
  int recv_stall = 0;
  int fails = 0;

  typedef struct {
    logic [31:0] max_value;
    logic        image_done;
  } pool_res_t;

  // Pooling predictor with its own line store and expected-result queue
  class pool_scoreboard;
    logic [8:0] height_r, width_r;
    logic [6:0] chans_r;
    logic [2:0] ph_r, pw_r, sr_r, sc_r;
    logic [31:0] lines [MPOOL*MWID*MCH];
    int unsigned row, col, chn;
    pool_res_t pending [$];

    function void clear();
      height_r = 2; width_r = 2; chans_r = 1;
      ph_r = 2; pw_r = 2; sr_r = 2; sc_r = 2;
      row = 0; col = 0; chn = 0;
    endfunction

    function void write_reg(logic [mps_pkg::CFG_IDX_W-1:0] idx, logic [8:0] v);
      case (mps_pkg::cfg_reg_e'(idx))
        mps_pkg::REG_IN_HEIGHT:   height_r = v;
        mps_pkg::REG_IN_WIDTH:    width_r = v;
        mps_pkg::REG_CHANNELS:    chans_r = v[6:0];
        mps_pkg::REG_POOL_HEIGHT: ph_r = v[2:0];
        mps_pkg::REG_POOL_WIDTH:  pw_r = v[2:0];
        mps_pkg::REG_STRIDE_ROWS: sr_r = v[2:0];
        mps_pkg::REG_STRIDE_COLS: sc_r = v[2:0];
        default: return;
      endcase
      row = 0; col = 0; chn = 0;
    endfunction

    static function int unsigned lim(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Ordered strict greater-than on float bits; NaN and equal give false
    static function bit gt(logic [31:0] a, logic [31:0] b);
      bit an, bn;
      an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      if (an || bn) return 0;
      if (a[30:0] == 0 && b[30:0] == 0) return 0;
      if (a[31] != b[31]) return !a[31];
      if (!a[31]) return a[30:0] > b[30:0];
      return a[30:0] < b[30:0];
    endfunction

    static function int unsigned slot(int unsigned r, int unsigned c, int unsigned ch);
      return ((r % MPOOL) * MWID + c) * MCH + ch;
    endfunction

    function void note_sample(logic [31:0] smp);
      int unsigned h, w, nc, ph, pw, sr, sc, oh, ow;
      logic [31:0] acc, v;
      pool_res_t res;
      h = lim(height_r, 256); w = lim(width_r, MWID); nc = lim(chans_r, MCH);
      ph = lim(ph_r, MPOOL); pw = lim(pw_r, MPOOL); sr = lim(sr_r, 7); sc = lim(sc_r, 7);
      if (row >= h || col >= w || chn >= nc) begin
        row = 0; col = 0; chn = 0;
      end
      lines[slot(row, col, chn)] = smp;
      if (ph <= h && pw <= w && row + 1 >= ph && col + 1 >= pw &&
          (row + 1 - ph) % sr == 0 && (col + 1 - pw) % sc == 0) begin
        oh = (row + 1 - ph) / sr;
        ow = (col + 1 - pw) / sc;
        acc = mps_pkg::NEG_INF;
        for (int kh = 0; kh < ph; kh++)
          for (int kw = 0; kw < pw; kw++) begin
            v = lines[slot(row + 1 - ph + kh, col + 1 - pw + kw, chn)];
            acc = gt(acc, v) ? acc : v;
          end
        res.max_value = acc;
        res.image_done = (oh + 1 == (h - ph) / sr + 1) && (ow + 1 == (w - pw) / sc + 1) &&
                         (chn + 1 == nc);
        pending.push_back(res);
      end
      chn++;
      if (chn >= nc) begin
        chn = 0; col++;
        if (col >= w) begin
          col = 0; row++;
          if (row >= h) row = 0;
        end
      end
    endfunction

    function int check_result(logic [31:0] mv, logic done);
      pool_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result max=%h done=%b", $time, mv, done);
        return 1;
      end
      e = pending.pop_front();
      if (e.max_value !== mv || e.image_done !== done) begin
        $display("%0t: mismatch expected max=%h done=%b actual max=%h done=%b",
                 $time, e.max_value, e.image_done, mv, done);
        return 1;
      end
      return 0;
    endfunction
  endclass

  pool_scoreboard pool_sb = new();

  max_pool_2d_stream_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last)
  );

  always #1 clk = ~clk;

  // Note accepted requests, check accepted results, stall the receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) pool_sb.note_sample(s_data);
      if (m_valid && m_ready) fails += pool_sb.check_result(m_data, m_last);
      m_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [mps_pkg::CFG_IDX_W-1:0] idx, logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
    pool_sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop the request, then wait out all results plus some settling time
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pool_sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Hold the request until accepted; idle cycles drop valid
  task automatic send(logic [31:0] smp);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1; s_data <= smp;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0: return 32'h7FC0_0000 | $urandom_range(1, 255);
      1: return mps_pkg::NEG_INF;
      2: return 32'h7F80_0000;
      3: return {1'($urandom_range(1)), 31'd0};
      4: return $urandom_range(1) ? 32'h3F80_0000 : 32'hBF80_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic setup(int h, int w, int c, int ph, int pw, int sr, int sc);
    write_reg(mps_pkg::REG_IN_HEIGHT, 9'(h)); write_reg(mps_pkg::REG_IN_WIDTH, 9'(w));
    write_reg(mps_pkg::REG_CHANNELS, 9'(c)); write_reg(mps_pkg::REG_POOL_HEIGHT, 9'(ph));
    write_reg(mps_pkg::REG_POOL_WIDTH, 9'(pw)); write_reg(mps_pkg::REG_STRIDE_ROWS, 9'(sr));
    write_reg(mps_pkg::REG_STRIDE_COLS, 9'(sc));
  endtask

  initial begin
    int count;
    pool_sb.clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset setting 2x2 window: ties, NaN, infinities, signed zeros
    send(32'h0000_0000); send(32'h8000_0000); send(32'h0000_0000); send(32'h8000_0000);
    send(32'h7FC0_0001); send(32'h3F80_0000); send(32'hFFFF_FFFF); send(32'h3F80_0000);
    send(mps_pkg::NEG_INF); send(mps_pkg::NEG_INF);
    send(mps_pkg::NEG_INF); send(mps_pkg::NEG_INF);
    send(32'h7F80_0000); send(32'hFFFF_FFFF); send(32'h0000_0001); send(32'h7FFF_FFFF);
    drain();
    // Pool larger than image, and zero / out-of-range settings
    setup(1, 3, 2, 4, 2, 1, 1);
    repeat (6) send($urandom);
    drain();
    setup(0, 0, 0, 0, 0, 0, 0);
    repeat (3) send($urandom);
    drain();
    write_reg(mps_pkg::CFG_IDX_W'(7), 9'h1FF);
    setup(3, 3, 127, 7, 7, 7, 7);
    repeat (5) send($urandom);
    drain();

    count = 0;
    for (int ph = 0; count < 850; ph++) begin
      int h, w, c, p, q, n;
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 71; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 71; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      p = $urandom_range(1, 4); q = $urandom_range(1, 4);
      h = $urandom_range(p, 8); w = $urandom_range(q, 8); c = $urandom_range(1, 3);
      if (ph == 1) begin h = 1; w = 256; c = 1; p = 1; q = 4; end
      if (ph == 2) begin h = 4; w = 1; c = 64; p = 4; q = 1; end
      setup(h, w, c, p, q, $urandom_range(1, 4), $urandom_range(1, 4));
      if (ph == 1 || ph == 2) n = h * w * c;
      else n = $urandom_range(1, 2) * h * w * c + $urandom_range(0, 3);
      if (count + n > 870) n = 870 - count;
      repeat (n) begin
        send(rand_float());
        count++;
      end
      drain();
    end
    drain();
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_store.sv
rtl/mps_ctrl.sv
rtl/mps_fold.sv
rtl/max_pool_2d_stream_top.sv
tb/sv/testbench.sv
